@@ rtl/dsm_pkg.sv @@
// Shared types, register map and reset values for the hood and level monitor.
// No dependencies.
`timescale 1ns / 1ps

package dsm_pkg;

    localparam int unsigned TimeW = 32;
    localparam int unsigned DataW = 32;
    localparam int unsigned AddrW = 4;

    typedef logic [TimeW-1:0] time_ms_t;

    typedef enum logic [1:0] {
        REG_HOOD_OPEN_DEB  = 2'd0,
        REG_HOOD_CLOSE_DEB = 2'd1,
        REG_CRIT_DEB       = 2'd2,
        REG_HOOD_LONG_OPEN = 2'd3
    } reg_idx_t;

    localparam time_ms_t HOOD_OPEN_DEB_RST  = 32'd50;
    localparam time_ms_t HOOD_CLOSE_DEB_RST = 32'd500;
    localparam time_ms_t CRIT_DEB_RST       = 32'd200;
    localparam time_ms_t HOOD_LONG_OPEN_RST = 32'd60000;

    typedef struct packed {
        time_ms_t hood_open_deb;
        time_ms_t hood_close_deb;
        time_ms_t crit_deb;
        time_ms_t hood_long_open;
    } cfg_t;

    typedef struct packed {
        logic     seen;
        logic     stable;
        logic     cand;
        time_ms_t since;
    } deb_state_t;

endpackage

@@ rtl/dsm_cfg_regs.sv @@
// APB-style configuration registers for the monitor.
// Depends on dsm_pkg.
`timescale 1ns / 1ps

module dsm_cfg_regs
    import dsm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_HOOD_OPEN_DEB:  cfg_next.hood_open_deb  = pwdata;
                REG_HOOD_CLOSE_DEB: cfg_next.hood_close_deb = pwdata;
                REG_CRIT_DEB:       cfg_next.crit_deb       = pwdata;
                REG_HOOD_LONG_OPEN: cfg_next.hood_long_open = pwdata;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_HOOD_OPEN_DEB:  prdata = cfg_reg.hood_open_deb;
            REG_HOOD_CLOSE_DEB: prdata = cfg_reg.hood_close_deb;
            REG_CRIT_DEB:       prdata = cfg_reg.crit_deb;
            REG_HOOD_LONG_OPEN: prdata = cfg_reg.hood_long_open;
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hood_open_deb  <= HOOD_OPEN_DEB_RST;
            cfg_reg.hood_close_deb <= HOOD_CLOSE_DEB_RST;
            cfg_reg.crit_deb       <= CRIT_DEB_RST;
            cfg_reg.hood_long_open <= HOOD_LONG_OPEN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/dsm_debounce.sv @@
// Candidate-and-timestamp debouncer step, purely combinational.
// Depends on dsm_pkg.
`timescale 1ns / 1ps

module dsm_debounce
    import dsm_pkg::*;
(
    input  logic       raw,
    input  time_ms_t   now,
    input  time_ms_t   delay,
    input  deb_state_t state_cur,
    output deb_state_t state_next,
    output logic       changed
);

    deb_state_t s0;
    deb_state_t s1;
    time_ms_t   elapsed;

    always_comb
    begin
        // take the first word straight from the raw level
        s0 = state_cur;
        if (!state_cur.seen)
        begin
            s0.seen   = 1'b1;
            s0.stable = raw;
            s0.cand   = raw;
            s0.since  = now;
        end

        // restart the timer on a new candidate
        s1 = s0;
        if (raw != s0.cand)
        begin
            s1.cand  = raw;
            s1.since = now;
        end

        elapsed = now - s1.since;
        changed = (s1.stable != s1.cand) && (elapsed >= delay);

        state_next = s1;
        if (changed)
        begin
            state_next.stable = s1.cand;
        end
    end

endmodule

@@ rtl/dual_input_debounce_safety_monitor_unit.sv @@
// Hood and critical level monitor: input word register, debounce logic, result register.
// Depends on dsm_pkg, dsm_cfg_regs and dsm_debounce.
// Flow: an accepted input word is held in the input register, and its result then moves into the result register.
// Throughput: one word per cycle while the output is not stalled; the input register drains into the result register.
// Reset: configuration returns to its default delays, debouncer state clears,
// and the first word after reset seeds both debouncers from its raw levels.
`timescale 1ns / 1ps

module dual_input_debounce_safety_monitor_unit
    import dsm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,

    input  logic             in_valid,
    output logic             in_ready,
    input  logic [TimeW-1:0] now_ms,
    input  logic             hood_raw,
    input  logic             critical_raw,
    input  logic             wash_raw,

    output logic             out_valid,
    input  logic             out_ready,
    output logic             hood_open,
    output logic             hood_open_long,
    output logic             level_critical,
    output logic             level_incoherent
);

    cfg_t       cfg;

    logic       in_valid_reg;
    time_ms_t   now_reg;
    logic       hood_raw_reg;
    logic       crit_raw_reg;
    logic       wash_raw_reg;

    deb_state_t hood_st_reg;
    deb_state_t hood_st_next;
    deb_state_t crit_st_reg;
    deb_state_t crit_st_next;
    time_ms_t   open_time_reg;
    time_ms_t   open_time_next;
    time_ms_t   open_time_seed;
    time_ms_t   hood_delay;
    logic       hood_changed;
    logic       crit_changed;
    logic       long_open;

    logic       out_valid_reg;
    logic       hood_open_reg;
    logic       hood_long_reg;
    logic       crit_reg;
    logic       incoh_reg;

    logic       advance;

    dsm_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign hood_delay = hood_raw_reg ? cfg.hood_open_deb : cfg.hood_close_deb;

    dsm_debounce u_hood_deb (
        .raw        (hood_raw_reg),
        .now        (now_reg),
        .delay      (hood_delay),
        .state_cur  (hood_st_reg),
        .state_next (hood_st_next),
        .changed    (hood_changed)
    );

    dsm_debounce u_crit_deb (
        .raw        (crit_raw_reg),
        .now        (now_reg),
        .delay      (cfg.crit_deb),
        .state_cur  (crit_st_reg),
        .state_next (crit_st_next),
        .changed    (crit_changed)
    );

    always_comb
    begin
        if (hood_st_reg.seen)
        begin
            open_time_seed = open_time_reg;
        end
        else
        begin
            open_time_seed = hood_raw_reg ? now_reg : '0;
        end

        // a fresh open edge gives zero elapsed time
        if (hood_changed && hood_st_next.stable)
        begin
            open_time_next = now_reg;
            long_open      = (cfg.hood_long_open == '0);
        end
        else
        begin
            open_time_next = open_time_seed;
            long_open      = hood_st_next.stable
                             && ((now_reg - open_time_seed) >= cfg.hood_long_open);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hood_st_reg   <= '0;
            crit_st_reg   <= '0;
            open_time_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                hood_st_reg   <= hood_st_next;
                crit_st_reg   <= crit_st_next;
                open_time_reg <= open_time_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            now_reg      <= now_ms;
            hood_raw_reg <= hood_raw;
            crit_raw_reg <= critical_raw;
            wash_raw_reg <= wash_raw;
        end
        if (advance)
        begin
            hood_open_reg <= hood_st_next.stable;
            hood_long_reg <= long_open;
            crit_reg      <= crit_st_next.stable;
            incoh_reg     <= crit_st_next.stable && !wash_raw_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign hood_open        = hood_open_reg;
    assign hood_open_long   = hood_long_reg;
    assign level_critical   = crit_reg;
    assign level_incoherent = incoh_reg;

endmodule
